[rtl/ctpm_pkg.sv]
// ----------------------------------------------------------------------------
// ctpm_pkg
// Shared types and codes for the cell-to-partition mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package ctpm_pkg;

  localparam int COORD_W     = 28;
  localparam int STATUS_W    = 3;
  localparam int INDEX_W     = 4;
  localparam int COUNT_W     = 32;
  localparam int DIST_W      = 30;

  localparam int DEF_MAX_PARTITIONS = 16;
  localparam int DEF_MAX_VERTICES   = 256;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [STATUS_W-1:0] ST_LOADED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_INSIDE  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NEAREST = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MACRO   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NONE    = 3'd5;

  typedef struct packed {
    logic               opcode;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic [COORD_W-1:0] cell_width;
    logic [COORD_W-1:0] cell_height;
    logic               end_of_polygon;
    logic               is_macro;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  partition_index;
    logic [COUNT_W-1:0]  cell_count;
    logic [DIST_W-1:0]   nearest_distance;
  } out_item_t;

endpackage

`default_nettype wire

[rtl/cell_to_partition_mapper_core.sv]
// ----------------------------------------------------------------------------
// cell_to_partition_mapper_core
// Builds partitions from streamed polygon vertices and maps cell midpoints
// to the enclosing partition, or to the nearest partition centre.
// ----------------------------------------------------------------------------
//   channel   | handshake          | payload
//   ----------+--------------------+-----------------------
//   command   | start / busy       | item   (in_item_t)
//   result    | done (1-cycle)     | result (out_item_t)
//
// Plain loads, drops, macro cells and empty-store queries answer in the cycle
// after the transfer and leave busy low. A closing load runs a bit-serial
// divider, busy until the centre is written. A query walks the partition
// table: per partition S_PREQ, S_PGET, for 3 or more vertices S_EDGE,
// streaming edges out of the vertex memory one edge a cycle, and S_PEVAL;
// then S_CREQ and S_CUPD update the count. No clearing pass after reset:
// cell counts carry one valid flop per partition. Results cannot be stalled.
`default_nettype none

module cell_to_partition_mapper_core #(
  parameter int MAX_PARTITIONS = ctpm_pkg::DEF_MAX_PARTITIONS,
  parameter int MAX_VERTICES   = ctpm_pkg::DEF_MAX_VERTICES
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire ctpm_pkg::in_item_t item,
  output logic                    busy,
  output logic                    done,
  output ctpm_pkg::out_item_t     result
);

  localparam int CRD = ctpm_pkg::COORD_W;
  localparam int VW  = $clog2(MAX_VERTICES);
  localparam int CW  = VW + 1;
  localparam int PW  = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
  localparam int SW  = CRD + VW;
  localparam int DCW = $clog2(SW);
  localparam int MW  = CRD + 1;
  localparam int DW  = MW + 1;
  localparam int PRW = 2 * DW;
  localparam int NW  = ctpm_pkg::COUNT_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIV   = 4'd1;
  localparam logic [3:0] S_PREQ  = 4'd2;
  localparam logic [3:0] S_PGET  = 4'd3;
  localparam logic [3:0] S_EDGE  = 4'd4;
  localparam logic [3:0] S_PEVAL = 4'd5;
  localparam logic [3:0] S_CREQ  = 4'd6;
  localparam logic [3:0] S_CUPD  = 4'd7;

  typedef struct packed {
    logic [CRD-1:0] x;
    logic [CRD-1:0] y;
  } vert_t;

  typedef struct packed {
    logic [VW-1:0]  first;
    logic [CW-1:0]  count;
    logic [CRD-1:0] cx;
    logic [CRD-1:0] cy;
  } ptab_t;

  // memories
  vert_t vert_mem [MAX_VERTICES];
  ptab_t ptab_mem [MAX_PARTITIONS];
  logic [NW-1:0] cnt_mem [MAX_PARTITIONS];
  logic [MAX_PARTITIONS-1:0] cnt_vld;

  vert_t         vert_q;
  ptab_t         ptab_q;
  logic [NW-1:0] cnt_q;

  logic [3:0]    state;
  logic [PW:0]   closed;
  logic [CW-1:0] vu;
  logic [CW-1:0] part_start;
  logic [SW-1:0] sum_x;
  logic [SW-1:0] sum_y;

  logic [SW-1:0]  dx, dy;
  logic [CW-1:0]  rx, ry, dn;
  logic [DCW-1:0] div_cnt;

  logic [MW-1:0]  mx, my;
  logic [PW-1:0]  p, chosen;
  logic [DW-1:0]  best, dist_p;
  logic           best_v;
  logic           in_poly;

  logic [CW-1:0]  rd_i;
  logic           s1_v, s1_first;
  vert_t          prev;
  logic           s2_v, s2_hit, s2_tog, s2_need, s2_bgta;
  logic signed [PRW-1:0] s2_p1, s2_p2;
  logic           odd, hit;

  // combinational
  logic          accept, is_load, full, vert_we, div_last, cnt_we, iss, done_next;
  logic [VW-1:0] vaddr;
  logic [CW:0]   trial_x, trial_y;
  logic          ge_x, ge_y;
  logic [SW-1:0] dx_next, dy_next;
  logic [CW-1:0] rx_next, ry_next;

  logic [MW-1:0] bxw, byw, axw, ayw;
  logic signed [DW-1:0] dax, day, dbx, dby;
  logic signed [PRW-1:0] p1, p2;
  logic          e_hit, e_str, e_tog, e_need;
  logic signed [PRW:0] dd;
  logic          c_hit, c_tog;

  logic [MW-1:0] cxw, cyw, adx, ady;
  logic [DW-1:0] dsum;
  logic [NW-1:0] cur_cnt, new_cnt;

  assign busy = (state != S_IDLE);

  always_comb begin
    accept  = start && !busy;
    is_load = (item.opcode == ctpm_pkg::OP_LOAD);
    full    = (vu >= CW'(MAX_VERTICES)) || (closed >= (PW + 1)'(MAX_PARTITIONS));
    vert_we = accept && is_load && !full;
    div_last = (state == S_DIV) && (div_cnt == DCW'(SW - 1));
    cnt_we  = (state == S_CUPD);
    iss     = (state == S_EDGE) && (rd_i <= ptab_q.count);
    vaddr   = (rd_i == ptab_q.count) ? ptab_q.first : ptab_q.first + rd_i[VW-1:0];
    done_next = (accept && (is_load ? (full || !item.end_of_polygon)
                                    : (item.is_macro || (closed == '0))))
                || div_last || cnt_we;

    // one restoring-division step for both coordinates
    trial_x = {rx, dx[SW-1]};
    trial_y = {ry, dy[SW-1]};
    ge_x    = trial_x >= {1'b0, dn};
    ge_y    = trial_y >= {1'b0, dn};
    rx_next = ge_x ? CW'(trial_x - {1'b0, dn}) : CW'(trial_x);
    ry_next = ge_y ? CW'(trial_y - {1'b0, dn}) : CW'(trial_y);
    dx_next = {dx[SW-2:0], ge_x};
    dy_next = {dy[SW-2:0], ge_y};

    // edge from prev (a) to vert_q (b) against midpoint
    axw = MW'(prev.x);
    ayw = MW'(prev.y);
    bxw = MW'(vert_q.x);
    byw = MW'(vert_q.y);
    dax = signed'({1'b0, axw}) - signed'({1'b0, mx});
    day = signed'({1'b0, ayw}) - signed'({1'b0, my});
    dbx = signed'({1'b0, bxw}) - signed'({1'b0, mx});
    dby = signed'({1'b0, byw}) - signed'({1'b0, my});
    p1  = PRW'(dax) * PRW'(dby);
    p2  = PRW'(dbx) * PRW'(day);
    e_hit  = (byw == my) && ((bxw == mx) || ((ayw == my) && ((bxw > mx) == (axw < mx))));
    e_str  = (ayw < my) != (byw < my);
    e_tog  = e_str && (axw >= mx) && (bxw > mx);
    e_need = e_str && (((axw >= mx) && !(bxw > mx)) || ((axw < mx) && (bxw > mx)));

    dd    = (PRW + 1)'(s2_p1) - (PRW + 1)'(s2_p2);
    c_hit = s2_need && (dd == '0);
    c_tog = s2_need && (dd != '0) && ((dd > 0) == s2_bgta);

    cxw  = MW'(ptab_q.cx);
    cyw  = MW'(ptab_q.cy);
    adx  = (mx >= cxw) ? mx - cxw : cxw - mx;
    ady  = (my >= cyw) ? my - cyw : cyw - my;
    dsum = DW'(adx) + DW'(ady);

    cur_cnt = cnt_vld[chosen] ? cnt_q : '0;
    new_cnt = (cur_cnt == '1) ? cur_cnt : cur_cnt + NW'(1);
  end

  // vertex memory
  always_ff @(posedge clk) begin
    if (vert_we) begin
      vert_mem[vu[VW-1:0]] <= '{x: item.coord_x, y: item.coord_y};
    end
    vert_q <= vert_mem[vaddr];
  end

  // partition table
  always_ff @(posedge clk) begin
    if (div_last) begin
      ptab_mem[closed[PW-1:0]] <= '{first: part_start[VW-1:0], count: dn,
                                    cx: dx_next[CRD-1:0], cy: dy_next[CRD-1:0]};
    end
    ptab_q <= ptab_mem[p];
  end

  // cell counts
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[chosen] <= new_cnt;
    end
    cnt_q <= cnt_mem[chosen];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_vld <= '0;
    end else if (cnt_we) begin
      cnt_vld[chosen] <= 1'b1;
    end
  end

  // edge pipeline payload
  always_ff @(posedge clk) begin
    if (s1_v) begin
      prev <= vert_q;
    end
    s2_hit  <= e_hit;
    s2_tog  <= e_tog;
    s2_need <= e_need;
    s2_bgta <= byw > ayw;
    s2_p1   <= p1;
    s2_p2   <= p2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      closed     <= '0;
      vu         <= '0;
      part_start <= '0;
      sum_x      <= '0;
      sum_y      <= '0;
      s1_v       <= 1'b0;
      s2_v       <= 1'b0;
    end else begin
      done <= done_next;
      s1_v <= iss;
      s2_v <= s1_v && !s1_first;
      if (iss) begin
        rd_i     <= rd_i + CW'(1);
        s1_first <= (rd_i == '0);
      end
      if (s2_v) begin
        odd <= odd ^ s2_tog ^ c_tog;
        hit <= hit | s2_hit | c_hit;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (is_load) begin
              if (full) begin
                result <= '{status: ctpm_pkg::ST_FULL, default: '0};
              end else begin
                result <= '{status: ctpm_pkg::ST_LOADED, default: '0};
                vu     <= vu + CW'(1);
                if (item.end_of_polygon) begin
                  dx      <= sum_x + SW'(item.coord_x);
                  dy      <= sum_y + SW'(item.coord_y);
                  rx      <= '0;
                  ry      <= '0;
                  dn      <= vu + CW'(1) - part_start;
                  div_cnt <= '0;
                  sum_x   <= '0;
                  sum_y   <= '0;
                  state   <= S_DIV;
                end else begin
                  sum_x <= sum_x + SW'(item.coord_x);
                  sum_y <= sum_y + SW'(item.coord_y);
                end
              end
            end else if (item.is_macro) begin
              result <= '{status: ctpm_pkg::ST_MACRO, default: '0};
            end else if (closed == '0) begin
              result <= '{status: ctpm_pkg::ST_NONE, default: '0};
            end else begin
              mx      <= MW'(item.coord_x) + MW'(item.cell_width >> 1);
              my      <= MW'(item.coord_y) + MW'(item.cell_height >> 1);
              p       <= '0;
              chosen  <= '0;
              best_v  <= 1'b0;
              in_poly <= 1'b0;
              state   <= S_PREQ;
            end
          end
        end
        S_DIV: begin
          dx      <= dx_next;
          dy      <= dy_next;
          rx      <= rx_next;
          ry      <= ry_next;
          div_cnt <= div_cnt + DCW'(1);
          if (div_last) begin
            closed     <= closed + (PW + 1)'(1);
            part_start <= vu;
            state      <= S_IDLE;
          end
        end
        S_PREQ: begin
          state <= S_PGET;
        end
        S_PGET: begin
          dist_p <= dsum;
          rd_i   <= '0;
          odd    <= 1'b0;
          hit    <= 1'b0;
          state  <= (ptab_q.count < CW'(3)) ? S_PEVAL : S_EDGE;
        end
        S_EDGE: begin
          if (!iss && !s1_v && !s2_v) begin
            state <= S_PEVAL;
          end
        end
        S_PEVAL: begin
          if (hit || odd) begin
            chosen  <= p;
            in_poly <= 1'b1;
            state   <= S_CREQ;
          end else begin
            if (!best_v || (dist_p < best)) begin
              best   <= dist_p;
              chosen <= p;
              best_v <= 1'b1;
            end
            if (({1'b0, p} + (PW + 1)'(1)) == closed) begin
              state <= S_CREQ;
            end else begin
              p     <= p + PW'(1);
              state <= S_PREQ;
            end
          end
        end
        S_CREQ: begin
          state <= S_CUPD;
        end
        S_CUPD: begin
          result <= '{status:           in_poly ? ctpm_pkg::ST_INSIDE : ctpm_pkg::ST_NEAREST,
                      partition_index:  ctpm_pkg::INDEX_W'(chosen),
                      cell_count:       new_cnt,
                      nearest_distance: in_poly ? '0 : best};
          state  <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // a plain load answers on the next cycle
  a_load_next: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.opcode == ctpm_pkg::OP_LOAD && !item.end_of_polygon) |=> done)
    else $error("plain load gave no result");

  // a result always comes with the block idle again
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result while busy");

  // a mapped cell always has a nonzero count
  a_count_nz: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == ctpm_pkg::ST_INSIDE || result.status == ctpm_pkg::ST_NEAREST))
      |-> (result.cell_count != '0))
    else $error("mapped cell with zero count");

endmodule

`default_nettype wire

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the cell-to-partition mapper: builds partitions from
// directed and random vertex streams, interleaves cell queries, and checks
// every result against a behavioral partition-lookup predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  localparam int NPART  = ctpm_pkg::DEF_MAX_PARTITIONS;
  localparam int NVERT  = ctpm_pkg::DEF_MAX_VERTICES;
  localparam int LIMIT  = 3000000;
  localparam int TAIL   = 100;
  localparam int CRD    = ctpm_pkg::COORD_W;
  localparam logic [CRD-1:0] CMAX = '1;

  logic                clk;
  logic                rst;
  logic                start;
  ctpm_pkg::in_item_t  item;
  logic                busy;
  logic                done;
  ctpm_pkg::out_item_t result;

  cell_to_partition_mapper_core uut (
    .clk(clk), .rst(rst), .start(start), .item(item),
    .busy(busy), .done(done), .result(result)
  );

  // predictor state
  logic [CRD-1:0]               vert_x [NVERT];
  logic [CRD-1:0]               vert_y [NVERT];
  int                           part_first [NPART];
  int                           part_len [NPART];
  logic [CRD-1:0]               centre_x [NPART];
  logic [CRD-1:0]               centre_y [NPART];
  logic [ctpm_pkg::COUNT_W-1:0] cells_in_part [NPART];
  int                           parts_closed;
  int                           verts_used;
  longint                       acc_x, acc_y;

  ctpm_pkg::in_item_t  pending_cmds [$];
  ctpm_pkg::out_item_t expected_results [$];
  int        errors = 0;
  int        cycles = 0;
  int        idle_left = 0;
  bit        xfer_seen = 0;

  function automatic bit holds_point(int p, longint px, longint py);
    int     first, cnt, k;
    bit     odd, need_cross;
    longint ax, ay, bx, by, d;
    first = part_first[p];
    cnt   = part_len[p];
    odd   = 0;
    if (cnt < 3) return 0;
    ax = vert_x[first % NVERT];
    ay = vert_y[first % NVERT];
    for (int i = 1; i <= cnt; i++) begin
      k  = (i == cnt) ? first : first + i;
      bx = vert_x[k % NVERT];
      by = vert_y[k % NVERT];
      if (by == py) begin
        if (bx == px || (ay == py && ((bx > px) == (ax < px)))) return 1;
      end
      if ((ay < py) != (by < py)) begin
        need_cross = 0;
        if (ax >= px) begin
          if (bx > px) odd = !odd;
          else need_cross = 1;
        end else if (bx > px) begin
          need_cross = 1;
        end
        if (need_cross) begin
          d = (ax - px) * (by - py) - (bx - px) * (ay - py);
          if (d == 0) return 1;
          if ((d > 0) == (by > ay)) odd = !odd;
        end
      end
      ax = bx;
      ay = by;
    end
    return odd;
  endfunction

  function automatic ctpm_pkg::out_item_t map_item(ctpm_pkg::in_item_t it);
    ctpm_pkg::out_item_t r;
    int        p, start_v, n, chosen;
    longint    mx, my, best, d;
    bit        in_poly;
    r = '0;
    if (it.opcode == ctpm_pkg::OP_LOAD) begin
      if (verts_used >= NVERT || parts_closed >= NPART) begin
        r.status = ctpm_pkg::ST_FULL;
      end else begin
        r.status = ctpm_pkg::ST_LOADED;
        vert_x[verts_used] = it.coord_x;
        vert_y[verts_used] = it.coord_y;
        verts_used++;
        acc_x += it.coord_x;
        acc_y += it.coord_y;
        if (it.end_of_polygon) begin
          p = parts_closed;
          start_v = (p > 0) ? part_first[p-1] + part_len[p-1] : 0;
          n = verts_used - start_v;
          part_first[p] = start_v;
          part_len[p]   = n;
          centre_x[p]   = CRD'(acc_x / n);
          centre_y[p]   = CRD'(acc_y / n);
          parts_closed  = p + 1;
          acc_x = 0;
          acc_y = 0;
        end
      end
    end else if (it.is_macro) begin
      r.status = ctpm_pkg::ST_MACRO;
    end else if (parts_closed == 0) begin
      r.status = ctpm_pkg::ST_NONE;
    end else begin
      mx = longint'(it.coord_x) + longint'(it.cell_width >> 1);
      my = longint'(it.coord_y) + longint'(it.cell_height >> 1);
      best = 64'h7fff_ffff_ffff_ffff;
      chosen = 0;
      in_poly = 0;
      for (p = 0; p < parts_closed; p++) begin
        if (holds_point(p, mx, my)) begin
          in_poly = 1;
          chosen = p;
          break;
        end
        d = ((mx >= centre_x[p]) ? mx - centre_x[p] : centre_x[p] - mx) +
            ((my >= centre_y[p]) ? my - centre_y[p] : centre_y[p] - my);
        if (d < best) begin
          best = d;
          chosen = p;
        end
      end
      if (in_poly) begin
        r.status = ctpm_pkg::ST_INSIDE;
      end else begin
        r.status = ctpm_pkg::ST_NEAREST;
        r.nearest_distance = ctpm_pkg::DIST_W'(best);
      end
      if (cells_in_part[chosen] != '1) cells_in_part[chosen]++;
      r.cell_count = cells_in_part[chosen];
      r.partition_index = ctpm_pkg::INDEX_W'(chosen);
    end
    return r;
  endfunction

  function automatic ctpm_pkg::in_item_t vertex(logic [CRD-1:0] x, logic [CRD-1:0] y,
                                                bit last);
    ctpm_pkg::in_item_t it;
    it = '0;
    it.opcode = ctpm_pkg::OP_LOAD;
    it.coord_x = x;
    it.coord_y = y;
    it.end_of_polygon = last;
    it.cell_width = CRD'($urandom);
    it.cell_height = CRD'($urandom);
    it.is_macro = $urandom_range(0, 1);
    return it;
  endfunction

  function automatic ctpm_pkg::in_item_t cell_item(logic [CRD-1:0] x, logic [CRD-1:0] y,
                                                   logic [CRD-1:0] w, logic [CRD-1:0] h,
                                                   bit macro);
    ctpm_pkg::in_item_t it;
    it = '0;
    it.opcode = ctpm_pkg::OP_QUERY;
    it.coord_x = x;
    it.coord_y = y;
    it.cell_width = w;
    it.cell_height = h;
    it.is_macro = macro;
    it.end_of_polygon = $urandom_range(0, 1);
    return it;
  endfunction

  function automatic logic [CRD-1:0] rand_coord(int base, int span);
    if ($urandom_range(0, 15) == 0) return CRD'($urandom);
    return CRD'(base + $urandom_range(0, span));
  endfunction

  task automatic queue_cmd(ctpm_pkg::in_item_t it);
    pending_cmds = {pending_cmds, it};
  endtask

  // ---------------- clock, reset, stimulus build, end of run ----------------
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    int closed_g, used_g, n, k, bx, by;
    rst = 1;
    start = 0;
    item = '0;
    foreach (cells_in_part[i]) cells_in_part[i] = '0;
    parts_closed = 0;
    verts_used = 0;
    acc_x = 0;
    acc_y = 0;

    // directed part
    queue_cmd(cell_item(10, 10, 4, 4, 0));             // nothing closed yet
    queue_cmd(cell_item(CMAX, CMAX, CMAX, CMAX, 1));   // macro
    queue_cmd(vertex(100, 100, 0));
    queue_cmd(vertex(200, 100, 0));
    queue_cmd(vertex(200, 200, 0));
    queue_cmd(vertex(100, 200, 1));
    queue_cmd(vertex(CMAX, CMAX, 1));                  // one-vertex partition
    queue_cmd(vertex(5000, 0, 0));
    queue_cmd(vertex(6000, 0, 1));                     // two-vertex partition
    queue_cmd(vertex(0, 0, 0));
    queue_cmd(vertex(CMAX, 0, 0));
    queue_cmd(vertex(0, CMAX, 1));
    queue_cmd(cell_item(140, 140, 20, 21, 0));         // inside square
    queue_cmd(cell_item(100, 150, 0, 0, 0));           // on left edge
    queue_cmd(cell_item(200, 200, 1, 1, 0));           // on a vertex
    queue_cmd(cell_item(150, 100, 0, 0, 0));           // on bottom edge
    queue_cmd(cell_item(CMAX, CMAX, CMAX, CMAX, 0));   // far corner, nearest
    queue_cmd(cell_item(5500, 0, 0, 0, 0));            // on two-vertex segment
    queue_cmd(cell_item(CMAX, 0, 0, 0, 0));            // triangle vertex
    queue_cmd(vertex(7, 9, 0));                        // left open for now
    queue_cmd(cell_item(7, 9, 0, 0, 0));               // unclosed vertex ignored
    closed_g = 4;
    used_g = 11;

    // random part: polygons with random content, queries interleaved
    n = 0;
    k = 0;
    bx = 0;
    by = 0;
    repeat (1500) begin
      if ($urandom_range(0, 2) == 0) begin
        queue_cmd(cell_item(rand_coord(0, 4600), rand_coord(0, 4600),
                            rand_coord(0, 700), rand_coord(0, 700),
                            $urandom_range(0, 9) == 0));
      end else if (closed_g >= NPART || used_g >= NVERT) begin
        queue_cmd(vertex(CRD'($urandom), CRD'($urandom), $urandom_range(0, 1)));
      end else begin
        if (n == 0) begin
          if (closed_g == NPART - 1) n = NVERT - used_g;
          else if ($urandom_range(0, 9) == 0) n = $urandom_range(1, 2);
          else n = $urandom_range(3, 10);
          k = 0;
          bx = $urandom_range(0, 4000);
          by = $urandom_range(0, 4000);
        end
        k++;
        queue_cmd(vertex(rand_coord(bx, 600), rand_coord(by, 600), k == n));
        used_g++;
        if (k == n) begin
          closed_g++;
          n = 0;
        end
      end
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;

    wait (pending_cmds.size() == 0 && !start);
    wait (expected_results.size() == 0);
    repeat (600) @(posedge clk);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------- driver ----------------
  always @(negedge clk) begin
    logic start_nxt;
    if (!rst) begin
      start_nxt = start;
      if (xfer_seen) start_nxt = 0;
      xfer_seen = 0;
      if (!start_nxt) begin
        if (idle_left > 0) begin
          idle_left--;
        end else if (pending_cmds.size() > 0) begin
          item <= pending_cmds.pop_front();
          start_nxt = 1;
          if (pending_cmds.size() > TAIL && $urandom_range(0, 7) == 0)
            idle_left = $urandom_range(1, 18);
        end
      end
      start <= start_nxt;
    end
  end

  // ---------------- monitor: transfer capture and result check ----------------
  always @(posedge clk) begin
    ctpm_pkg::out_item_t want;
    if (!rst) begin
      if (start && !busy) begin
        expected_results = {expected_results, map_item(item)};
        xfer_seen = 1;
      end
      if (done) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result %p", result);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (result.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, result.status);
            errors++;
          end
          if (result.partition_index !== want.partition_index) begin
            $error("partition_index: expected %0d, got %0d",
                   want.partition_index, result.partition_index);
            errors++;
          end
          if (result.cell_count !== want.cell_count) begin
            $error("cell_count: expected %0d, got %0d", want.cell_count, result.cell_count);
            errors++;
          end
          if (result.nearest_distance !== want.nearest_distance) begin
            $error("nearest_distance: expected %0d, got %0d",
                   want.nearest_distance, result.nearest_distance);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule

`default_nettype wire
